>>> hdl/aafc_pkg.sv
// Shared types, widths and helpers for the AABB frustum cull block.
// Used by every module under hdl; depends on nothing.
package aafc_pkg;

    // Field widths of the stream payloads and of the plane registers.
    localparam int COORD_W   = 16;  // Q11.4 box coordinate
    localparam int NORM_W    = 16;  // Q1.14 normal component
    localparam int DIST_W    = 16;  // Q11.4 plane distance
    localparam int PLANE_W   = 64;  // packed plane register
    localparam int AXES      = 3;

    // Arithmetic widths: a product is exact in 32 bits, the sum of three
    // products and the aligned distance stays below 2^33 in magnitude.
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 34;
    localparam int FRAC_ALIGN = 14;

    // Bit positions inside a plane register.
    localparam int NX_LSB   = 48;
    localparam int DIST_LSB = 0;

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = 2 * AXES * COORD_W;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int REG_COUNT  = 6;

    // Defaults for the top-level parameters.
    localparam int NUM_PLANES_DEF = 6;
    localparam int FIFO_DEPTH_DEF = 4;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PLANE_LEFT,
        REG_PLANE_RIGHT,
        REG_PLANE_BOTTOM,
        REG_PLANE_TOP,
        REG_PLANE_NEAR,
        REG_PLANE_FAR
    } reg_idx_t;

    // Normal component of one axis (x is the highest field).
    function automatic logic [NORM_W-1:0] norm_of(input logic [PLANE_W-1:0] plane,
                                                  input int axis);
        norm_of = plane[NX_LSB - axis * NORM_W +: NORM_W];
    endfunction

    // Plane distance field.
    function automatic logic [DIST_W-1:0] dist_of(input logic [PLANE_W-1:0] plane);
        dist_of = plane[DIST_LSB +: DIST_W];
    endfunction

endpackage

>>> hdl/aafc_front.sv
// Front end: accepts a box word and picks the positive vertex of every plane.
// Depends on aafc_pkg; feeds the vertex queue.
module aafc_front #(
    parameter int NUM_PLANES = aafc_pkg::NUM_PLANES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [aafc_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic [NUM_PLANES-1:0][aafc_pkg::PLANE_W-1:0] planes,
    output logic                                   push_valid,
    input  logic                                   push_ready,
    output logic [NUM_PLANES-1:0][aafc_pkg::AXES-1:0][aafc_pkg::COORD_W-1:0] push_vert
);
    import aafc_pkg::*;

    logic                                          fv_reg;
    logic                                          fv_next;
    logic [NUM_PLANES-1:0][AXES-1:0][COORD_W-1:0]  vert_reg;
    logic [NUM_PLANES-1:0][AXES-1:0][COORD_W-1:0]  vert_next;

    // The stage takes a new word whenever it is empty or its word moves on.
    assign s_tready   = !fv_reg || push_ready;
    assign push_valid = fv_reg;
    assign push_vert  = vert_reg;

    // Per plane and axis: box max where the normal is strictly positive.
    always_comb begin
        logic [NORM_W-1:0] n;
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int a = 0; a < AXES; a++) begin
                n = norm_of(planes[p], a);
                if (!n[NORM_W-1] && (n != '0)) begin
                    vert_next[p][a] = s_tdata[(AXES + a) * COORD_W +: COORD_W];
                end else begin
                    vert_next[p][a] = s_tdata[a * COORD_W +: COORD_W];
                end
            end
        end
    end

    assign fv_next = s_tready ? s_tvalid : fv_reg;

    // Valid flag under reset; the vertex word loads on acceptance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else begin
            fv_reg <= fv_next;
        end
        if (s_tvalid && s_tready) begin
            vert_reg <= vert_next;
        end
    end

endmodule

>>> hdl/aafc_fifo.sv
// Small queue that decouples the vertex front end from the dot-product back end.
// Depends on aafc_pkg for the default depth; generic in width and depth.
module aafc_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = aafc_pkg::FIFO_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);
    import aafc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointer wrap that works for any depth.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        ptr_inc = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hdl/aafc_back.sv
// Back end: multiplies the vertices by the normals, adds the distance and
// merges the plane signs into the visible flag. Depends on aafc_pkg.
module aafc_back #(
    parameter int NUM_PLANES = aafc_pkg::NUM_PLANES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   pop_valid,
    output logic                                   pop_ready,
    input  logic [NUM_PLANES-1:0][aafc_pkg::AXES-1:0][aafc_pkg::COORD_W-1:0] pop_vert,
    input  logic [NUM_PLANES-1:0][aafc_pkg::PLANE_W-1:0] planes,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [aafc_pkg::M_TDATA_W-1:0]         m_tdata
);
    import aafc_pkg::*;

    logic                                         pv_reg;
    logic                                         ov_reg;
    logic                                         vis_reg;
    logic                                         vis_next;
    logic                                         o_ready;
    logic [NUM_PLANES-1:0][AXES-1:0][PROD_W-1:0]  prod_reg;
    logic [NUM_PLANES-1:0][AXES-1:0][PROD_W-1:0]  prod_next;

    // Each stage loads when it is empty or the stage after it moves.
    assign o_ready   = !ov_reg || m_tready;
    assign pop_ready = !pv_reg || o_ready;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = {{(M_TDATA_W - 1){1'b0}}, vis_reg};

    // Product stage: one multiplier per plane and axis.
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int a = 0; a < AXES; a++) begin
                prod_next[p][a] = PROD_W'($signed(pop_vert[p][a])
                                          * $signed(norm_of(planes[p], a)));
            end
        end
    end

    // Sum stage: three products plus the distance aligned to Q.18; any
    // negative sum rejects the box.
    always_comb begin
        logic signed [SUM_W-1:0] acc;
        vis_next = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++) begin
            acc = SUM_W'($signed(dist_of(planes[p]))) <<< FRAC_ALIGN;
            for (int a = 0; a < AXES; a++) begin
                acc = acc + SUM_W'($signed(prod_reg[p][a]));
            end
            if (acc[SUM_W-1]) begin
                vis_next = 1'b0;
            end
        end
    end

    // Stage valid flags under reset; payloads load with their stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (pop_ready) begin
                pv_reg <= pop_valid;
            end
            if (o_ready) begin
                ov_reg <= pv_reg;
            end
        end
        if (pop_ready && pop_valid) begin
            prod_reg <= prod_next;
        end
        if (o_ready && pv_reg) begin
            vis_reg <= vis_next;
        end
    end

endmodule

>>> hdl/aabb_frustum_cull_top.sv
// Top level of the AABB frustum cull block: plane registers, front end,
// vertex queue and back end. Depends on aafc_pkg, aafc_front, aafc_fifo, aafc_back.
//
//  Channel   Direction  Word                                     Handshake
//  s_*       in         box min x,y,z / max x,y,z (96 bits)      tvalid/tready
//  m_*       out        visible flag (bit 0, 8 bits)             tvalid/tready
//  cfg_*     in         plane register write, index 0..5         cfg_we, no wait
//
//  One box per cycle sustained while m_tready stays high. A result word is registered
//  on its way: the accepted box passes the front vertex register, the queue
//  and the product register into the result register.
//  Reset is synchronous and active low; it clears all planes to zero, so every
//  box reads visible until planes are written.
//  A stalled result holds the back end; FIFO_DEPTH + 3 boxes are then held
//  (result, product, queue and front registers) before s_tready drops.
module aabb_frustum_cull_top #(
    parameter int NUM_PLANES = aafc_pkg::NUM_PLANES_DEF,
    parameter int FIFO_DEPTH = aafc_pkg::FIFO_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [aafc_pkg::S_TDATA_W-1:0]    s_tdata,
    // visible, then zero padding
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [aafc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [aafc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [aafc_pkg::PLANE_W-1:0]      cfg_wdata
);
    import aafc_pkg::*;

    localparam int VERT_W = NUM_PLANES * AXES * COORD_W;

    logic [PLANE_W-1:0]                          plane_reg [REG_COUNT];
    logic [NUM_PLANES-1:0][PLANE_W-1:0]          planes;
    logic                                        push_valid;
    logic                                        push_ready;
    logic [NUM_PLANES-1:0][AXES-1:0][COORD_W-1:0] push_vert;
    logic                                        pop_valid;
    logic                                        pop_ready;
    logic [NUM_PLANES-1:0][AXES-1:0][COORD_W-1:0] pop_vert;

    // Plane registers; writes beyond the last plane are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_we && (cfg_addr <= REG_PLANE_FAR)) begin
            plane_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // Planes without a register stay zero and never reject.
    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        if (p < REG_COUNT) begin : g_reg
            assign planes[p] = plane_reg[p];
        end else begin : g_zero
            assign planes[p] = '0;
        end
    end

    aafc_front #(
        .NUM_PLANES (NUM_PLANES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .planes     (planes),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_vert  (push_vert)
    );

    aafc_fifo #(
        .DATA_W (VERT_W),
        .DEPTH  (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_vert),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_vert)
    );

    aafc_back #(
        .NUM_PLANES (NUM_PLANES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_vert  (pop_vert),
        .planes    (planes),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> hdl/aafc_checker.sv
// Port-level checks for the AABB frustum cull block, bound to the top level.
// Depends on aafc_pkg and aabb_frustum_cull_top.
module aafc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [aafc_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                              cfg_we
);
    import aafc_pkg::*;

    logic [3:0] pending_reg;
    logic       cfg_seen_reg;

    // Words in flight and whether any plane was written since reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= '0;
            cfg_seen_reg <= 1'b0;
        end else begin
            pending_reg <= pending_reg + 4'(s_tvalid && s_tready)
                                       - 4'(m_tvalid && m_tready);
            if (cfg_we) begin
                cfg_seen_reg <= 1'b1;
            end
        end
    end

    // A result word never shows without a box behind it.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != '0)
        else $error("result word without a pending box");

    // With all planes zero every box is visible.
    a_reset_planes_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !cfg_seen_reg) |-> m_tdata[0])
        else $error("box culled by zero planes");

    // Padding bits of the result word stay zero.
    a_padding_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:1] == '0)
        else $error("nonzero padding in result word");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

    // Reset empties the output.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind aabb_frustum_cull_top aafc_checker u_aafc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we)
);
